/* rtl/core/scfrf_pkg.sv */
package scfrf_pkg;

    localparam logic [7:0] HEAD_MARK = 8'h7e;
    localparam logic [7:0] TAIL_MARK = 8'h7d;
    localparam int FRAME_BYTES = 16;
    localparam int HIT_W = 7;

    // request kinds on the input channel
    localparam logic FUNC_RX_BYTE = 1'b0;
    localparam logic FUNC_WRITE_ENTRY = 1'b1;

    // result status codes
    localparam logic [2:0] STAT_DELIVERED = 3'd0;
    localparam logic [2:0] STAT_NO_HANDLER = 3'd1;
    localparam logic [2:0] STAT_NO_MATCH = 3'd2;
    localparam logic [2:0] STAT_BAD_FRAMING = 3'd3;
    localparam logic [2:0] STAT_NOT_EXT_DATA = 3'd4;
    localparam logic [2:0] STAT_BAD_CHANNEL = 3'd5;

    typedef struct packed {
        logic        extended;
        logic        has_handler;
        logic [7:0]  handler;
        logic [31:0] mask;
        logic [31:0] id;
    } filt_entry_t;

    typedef struct packed {
        logic        start;
        logic [31:0] id;
    } scan_req_t;

    typedef struct packed {
        logic             done;
        logic             found;
        logic             has_handler;
        logic [7:0]       handler;
        logic [HIT_W-1:0] index;
    } scan_hit_t;

endpackage

/* rtl/core/scfrf_filter_table.sv */
module scfrf_filter_table
    import scfrf_pkg::*;
#(
    parameter int FILTER_SLOTS = 128
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [HIT_W-1:0]  wr_idx,
    input  filt_entry_t       wr_entry,
    input  scan_req_t         scan,
    output logic              ready,
    output scan_hit_t         hit
);

    localparam int SLOT_W = (FILTER_SLOTS > 1) ? $clog2(FILTER_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FILTER_SLOTS - 1);

    localparam logic [1:0] T_CLEAR = 2'd0;
    localparam logic [1:0] T_IDLE = 2'd1;
    localparam logic [1:0] T_SCAN = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [SLOT_W-1:0] clr_idx_reg, clr_idx_next;
    logic [SLOT_W-1:0] cmp_idx_reg, cmp_idx_next;

    filt_entry_t       mem [FILTER_SLOTS];
    filt_entry_t       rd_data_reg;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_wa;
    filt_entry_t       mem_wd;
    logic [SLOT_W-1:0] mem_ra;
    logic              match;
    logic              last;

    always_comb
    begin
        if (state_reg == T_CLEAR)
        begin
            mem_we = 1'b1;
            mem_wa = clr_idx_reg;
            mem_wd = '0;
        end
        else
        begin
            mem_we = (state_reg == T_IDLE) && wr_en && (32'(wr_idx) < FILTER_SLOTS);
            mem_wa = SLOT_W'(wr_idx);
            mem_wd = wr_entry;
        end
    end

    // fetch one slot ahead of the compare
    assign last = (cmp_idx_reg == LAST_SLOT);
    assign mem_ra = (state_reg == T_SCAN && !last) ? cmp_idx_reg + SLOT_W'(1) : '0;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    assign match = ((scan.id & rd_data_reg.mask) == rd_data_reg.id);

    assign ready = (state_reg == T_IDLE);
    assign hit.done = (state_reg == T_SCAN) && (match || last);
    assign hit.found = match;
    assign hit.has_handler = rd_data_reg.has_handler;
    assign hit.handler = rd_data_reg.handler;
    assign hit.index = HIT_W'(cmp_idx_reg);

    always_comb
    begin
        state_next = state_reg;
        clr_idx_next = clr_idx_reg;
        cmp_idx_next = cmp_idx_reg;
        case (state_reg)
            T_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + SLOT_W'(1);
                if (clr_idx_reg == LAST_SLOT)
                begin
                    state_next = T_IDLE;
                end
            end
            T_IDLE:
            begin
                cmp_idx_next = '0;
                if (scan.start)
                begin
                    state_next = T_SCAN;
                end
            end
            T_SCAN:
            begin
                if (hit.done)
                begin
                    state_next = T_IDLE;
                end
                else
                begin
                    cmp_idx_next = cmp_idx_reg + SLOT_W'(1);
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_CLEAR;
            clr_idx_reg <= '0;
            cmp_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_idx_reg <= clr_idx_next;
            cmp_idx_reg <= cmp_idx_next;
        end
    end

endmodule

/* rtl/core/spi_can_frame_receive_filter.sv */
// channel  | handshake            | carries
// ---------+----------------------+------------------------------------------------
// in       | in_valid / in_ready  | func, rx_byte, entry_index .. entry_handler
// out      | out_valid / out_ready| status, frame_*, hit_index, hit_handler
//
// a frame byte or a filter write is taken on its handshake; the last byte of a frame that
// passes the checks starts a scan of the filter table, one slot a cycle through
// the table's single read port, ending at the first hit or at the last slot; input
// is stalled during the scan and while a result is held.
// after reset a clearing pass zeroes the table, input not ready meanwhile.
module spi_can_frame_receive_filter
    import scfrf_pkg::*;
#(
    parameter int FILTER_SLOTS = 128,
    parameter int CHANNEL_COUNT = 1
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [7:0]  rx_byte,
    input  logic [6:0]  entry_index,
    input  logic [31:0] entry_id,
    input  logic [31:0] entry_mask,
    input  logic        entry_extended,
    input  logic        entry_has_handler,
    input  logic [7:0]  entry_handler,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] frame_id,
    output logic [3:0]  frame_dlc,
    output logic [1:0]  frame_rtr,
    output logic        frame_extended,
    output logic [63:0] frame_payload,
    output logic [6:0]  hit_index,
    output logic [7:0]  hit_handler
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;
    localparam logic [3:0] LAST_POS = 4'(FRAME_BYTES - 1);

    logic             state_reg, state_next;
    logic [3:0]       pos_reg, pos_next;
    logic [7:0]       xor_reg, xor_next;
    logic             out_valid_reg, out_valid_next;
    logic [2:0]       status_reg, status_next;
    logic [HIT_W-1:0] hit_index_reg, hit_index_next;
    logic [7:0]       hit_handler_reg, hit_handler_next;
    logic [7:0]       store [FRAME_BYTES];

    logic             tbl_ready;
    scan_hit_t        hit;
    scan_req_t        scan;
    filt_entry_t      wr_entry;
    logic             in_fire;
    logic             byte_fire;
    logic             frame_end;
    logic             marks_ok;
    logic             ext_data_ok;
    logic             chan_ok;
    logic [7:0]       flags;

    assign in_ready = (state_reg == S_IDLE) && tbl_ready && !out_valid_reg;
    assign in_fire = in_valid && in_ready;
    assign byte_fire = in_fire && (func == FUNC_RX_BYTE);
    assign frame_end = byte_fire && (pos_reg == LAST_POS);

    always_ff @(posedge clk)
    begin
        if (byte_fire)
        begin
            store[pos_reg] <= rx_byte;
        end
    end

    // last byte is checked against the running xor as it arrives
    assign flags = store[1];
    assign marks_ok = (store[0] == HEAD_MARK) && (store[14] == TAIL_MARK)
                      && (rx_byte == xor_reg);
    assign ext_data_ok = flags[6] && (flags[5:4] == 2'b00);
    assign chan_ok = (32'(flags[7]) < CHANNEL_COUNT);

    assign frame_id = {store[5], store[4], store[3], store[2]};
    assign frame_dlc = flags[3:0];
    assign frame_rtr = flags[5:4];
    assign frame_extended = flags[6];
    assign frame_payload = {store[13], store[12], store[11], store[10],
                            store[9], store[8], store[7], store[6]};

    assign scan.start = frame_end && marks_ok && ext_data_ok && chan_ok;
    assign scan.id = frame_id;

    assign wr_entry.extended = entry_extended;
    assign wr_entry.has_handler = entry_has_handler;
    assign wr_entry.handler = entry_handler;
    assign wr_entry.mask = entry_mask;
    assign wr_entry.id = entry_id;

    scfrf_filter_table #(
        .FILTER_SLOTS (FILTER_SLOTS)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (in_fire && (func == FUNC_WRITE_ENTRY)),
        .wr_idx   (entry_index),
        .wr_entry (wr_entry),
        .scan     (scan),
        .ready    (tbl_ready),
        .hit      (hit)
    );

    always_comb
    begin
        state_next = state_reg;
        pos_next = pos_reg;
        xor_next = xor_reg;
        out_valid_next = out_valid_reg;
        status_next = status_reg;
        hit_index_next = hit_index_reg;
        hit_handler_next = hit_handler_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (byte_fire)
                begin
                    if (frame_end)
                    begin
                        pos_next = '0;
                        xor_next = '0;
                        hit_index_next = '0;
                        hit_handler_next = '0;
                        if (scan.start)
                        begin
                            state_next = S_SCAN;
                        end
                        else
                        begin
                            out_valid_next = 1'b1;
                            if (!marks_ok)
                            begin
                                status_next = STAT_BAD_FRAMING;
                            end
                            else if (!ext_data_ok)
                            begin
                                status_next = STAT_NOT_EXT_DATA;
                            end
                            else
                            begin
                                status_next = STAT_BAD_CHANNEL;
                            end
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + 4'd1;
                        xor_next = xor_reg ^ rx_byte;
                    end
                end
            end
            S_SCAN:
            begin
                if (hit.done)
                begin
                    state_next = S_IDLE;
                    out_valid_next = 1'b1;
                    if (!hit.found)
                    begin
                        status_next = STAT_NO_MATCH;
                        hit_index_next = '0;
                        hit_handler_next = '0;
                    end
                    else if (hit.has_handler)
                    begin
                        status_next = STAT_DELIVERED;
                        hit_index_next = hit.index;
                        hit_handler_next = hit.handler;
                    end
                    else
                    begin
                        status_next = STAT_NO_HANDLER;
                        hit_index_next = hit.index;
                        hit_handler_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pos_reg <= '0;
            xor_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg <= pos_next;
            xor_reg <= xor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        hit_index_reg <= hit_index_next;
        hit_handler_reg <= hit_handler_next;
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign hit_index = hit_index_reg;
    assign hit_handler = hit_handler_reg;

    // a result appears only after a scan or a rejected frame end
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past((state_reg == S_SCAN) || frame_end))
        else $error("result without a finished frame");

    // frame counting is parked at zero for the whole scan
    a_scan_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (pos_reg == 4'd0) && !out_valid_reg)
        else $error("byte position moved during scan");

    // handler tag only travels with a delivered frame
    a_handler_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg != STAT_DELIVERED) |-> (hit_handler_reg == 8'd0))
        else $error("handler tag on a frame that was not delivered");

    // frames rejected before the scan, and frames with no match, report slot zero
    a_reject_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ((status_reg == STAT_BAD_FRAMING)
        || (status_reg == STAT_NOT_EXT_DATA) || (status_reg == STAT_BAD_CHANNEL)
        || (status_reg == STAT_NO_MATCH)) |-> (hit_index_reg == '0))
        else $error("hit index set on a frame without a hit");

endmodule
